// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the checker file ssme_chk.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, suspended while reset is asserted
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_CLK_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/ssme_pkg.sv =====
// ---------------------------------------------------------------------------
// ssme_pkg
// Types and constants of the string mask encoder.
// ---------------------------------------------------------------------------
package ssme_pkg;

  localparam int GROUP_SIZE  = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [7:0] byte_t;
  typedef logic [2:0] cnt_t;

  localparam byte_t MASK_INIT = 8'h01;
  localparam cnt_t  LAST_POS  = cnt_t'(GROUP_SIZE - 1);

  typedef struct packed {
    byte_t [GROUP_SIZE-1:0] bytes;
    byte_t                  mask;
    cnt_t                   count;
    logic                   last;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } q_head_t;

endpackage

// ===== rtl/ssme_in_if.sv =====
// ---------------------------------------------------------------------------
// ssme_in_if
// Input byte channel: valid/ready handshake with message byte and end flag.
// ---------------------------------------------------------------------------
interface ssme_in_if;
  logic           valid;
  logic           ready;
  ssme_pkg::byte_t data_byte;
  logic           last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// ===== rtl/ssme_out_if.sv =====
// ---------------------------------------------------------------------------
// ssme_out_if
// Result channel: valid/ready handshake with encoded byte and end flags.
// ---------------------------------------------------------------------------
interface ssme_out_if;
  logic           valid;
  logic           ready;
  ssme_pkg::byte_t out_byte;
  logic           group_end;
  logic           message_end;

  modport source (output valid, out_byte, group_end, message_end, input ready);
  modport sink   (input valid, out_byte, group_end, message_end, output ready);
endinterface

// ===== rtl/stat_string_mask_encoder_top.sv =====
// Flow: a closing byte's group is written into the group queue, and its mask byte is then loaded
//   into the registered output stage once earlier groups have left. A group of n bytes (n = 1..7)
//   leaves as n+1 transactions, one per cycle while out_ch is ready.
// The input side runs one byte per cycle while the two-entry group queue has room.
// Reset: synchronous, active low; clears group count, mask, queue and output valid.
// ---------------------------------------------------------------------------
// stat_string_mask_encoder_top
// Byte stream mask encoder: front encoder, group queue and output sequencer.
// ---------------------------------------------------------------------------
module stat_string_mask_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  ssme_in_if.sink     in_ch,
  ssme_out_if.source  out_ch
);

  logic              push;
  logic              pop;
  logic              q_full;
  ssme_pkg::group_t  push_grp;
  ssme_pkg::q_head_t head;

  ssme_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  ssme_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  ssme_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/ssme_front.sv =====
// ---------------------------------------------------------------------------
// ssme_front
// Accepts bytes, encodes them, builds the group mask and hands finished
// groups to the queue.
// ---------------------------------------------------------------------------
module ssme_front (
  input  logic                 clk,
  input  logic                 rst_n,
  ssme_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 push,
  output ssme_pkg::group_t     push_grp
);

  ssme_pkg::byte_t [ssme_pkg::GROUP_SIZE-1:0] buf_r;
  ssme_pkg::cnt_t  count_r;
  ssme_pkg::byte_t mask_r;

  ssme_pkg::byte_t enc;
  ssme_pkg::byte_t mask_nxt;
  ssme_pkg::cnt_t  count_nxt;
  logic            accept;
  logic            flush;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // even byte plus one and odd byte kept both give the byte with bit 0 set
  assign enc       = in_ch.data_byte | ssme_pkg::byte_t'(1);
  assign count_nxt = count_r + 3'd1;
  assign mask_nxt  = in_ch.data_byte[0] ? (mask_r | (ssme_pkg::byte_t'(1) << count_nxt))
                                        : mask_r;
  assign flush     = (count_r == ssme_pkg::LAST_POS) || in_ch.last_byte;

  always_comb begin
    push_grp            = '0;
    push_grp.bytes      = buf_r;
    push_grp.bytes[count_r[2:0]] = enc;
    push_grp.mask       = mask_nxt;
    push_grp.count      = count_nxt;
    push_grp.last       = in_ch.last_byte;
  end

  assign push = accept && flush;

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r[count_r] <= enc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mask_r  <= ssme_pkg::MASK_INIT;
    end else if (accept) begin
      if (flush) begin
        count_r <= '0;
        mask_r  <= ssme_pkg::MASK_INIT;
      end else begin
        count_r <= count_nxt;
        mask_r  <= mask_nxt;
      end
    end
  end

endmodule

// ===== rtl/ssme_queue.sv =====
// ---------------------------------------------------------------------------
// ssme_queue
// Short group queue between the front and back parts.
// ---------------------------------------------------------------------------
module ssme_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ssme_pkg::group_t     push_grp,
  output logic                 full,
  input  logic                 pop,
  output ssme_pkg::q_head_t    head
);

  ssme_pkg::group_t            slot_r [ssme_pkg::QUEUE_DEPTH];
  logic [ssme_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [ssme_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [ssme_pkg::QCNT_W-1:0] cnt_r;
  logic [ssme_pkg::QCNT_W-1:0] cnt_nxt;

  assign full       = (cnt_r == ssme_pkg::QCNT_W'(ssme_pkg::QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.grp   = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + ssme_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - ssme_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == ssme_pkg::QPTR_W'(ssme_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == ssme_pkg::QPTR_W'(ssme_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/ssme_back.sv =====
// ---------------------------------------------------------------------------
// ssme_back
// Walks the head group: mask byte first, then the encoded bytes, through a
// registered output stage.
// ---------------------------------------------------------------------------
module ssme_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssme_pkg::q_head_t    head,
  output logic                 pop,
  ssme_out_if.source           out_ch
);

  logic            out_valid_r;
  ssme_pkg::byte_t out_byte_r;
  logic            group_end_r;
  logic            message_end_r;
  ssme_pkg::cnt_t  idx_r;
  ssme_pkg::cnt_t  idx_m1;
  ssme_pkg::byte_t sel_byte;
  logic            load;
  logic            fin;

  assign load   = head.valid && (!out_valid_r || out_ch.ready);
  assign fin    = (idx_r == head.grp.count);
  assign idx_m1 = idx_r - 3'd1;
  assign sel_byte = (idx_r == '0) ? head.grp.mask : head.grp.bytes[idx_m1];
  assign pop    = load && fin;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.group_end   = group_end_r;
  assign out_ch.message_end = message_end_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r    <= sel_byte;
      group_end_r   <= fin;
      message_end_r <= fin && head.grp.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= fin ? '0 : idx_r + 3'd1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/ssme_chk.sv =====
// ---------------------------------------------------------------------------
// ssme_chk
// Port-level checks of the string mask encoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssme_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input ssme_pkg::byte_t out_byte,
  input logic            group_end,
  input logic            message_end
);

  `ASSERT_CLK_NR(a_reset_idle, clk, !rst_n |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(group_end) && $stable(message_end), "stalled output changed")
  `ASSERT_CLK(a_msg_in_grp, clk, rst_n, out_valid && message_end |-> group_end, "message end without group end")
  `ASSERT_CLK(a_odd_byte, clk, rst_n, out_valid |-> out_byte[0], "emitted byte has bit 0 clear")

endmodule

bind stat_string_mask_encoder_top ssme_chk u_ssme_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .group_end   (out_ch.group_end),
  .message_end (out_ch.message_end)
);
